>>> design/scu_pkg.sv
package scu_pkg;

   // Word format: signed fixed point, WORD_BITS total with FRAC_BITS fraction bits
   localparam int WORD_BITS = 48;
   localparam int FRAC_BITS = 16;
   localparam int INT_BITS  = WORD_BITS - FRAC_BITS;
   localparam int PROD_BITS = 2 * WORD_BITS;

   // Multiply unit: one digit of the second operand per cycle
   localparam int MUL_DIGIT     = 16;
   localparam int MUL_STEPS     = (WORD_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int MUL_CNT_BITS  = $clog2(MUL_STEPS);
   localparam int PP_BITS       = WORD_BITS + MUL_DIGIT;

   // Divide unit: one quotient bit per cycle over the scaled numerator
   localparam int NUM_BITS      = WORD_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [PROD_BITS-1:0] prod_type;
   typedef logic [NUM_BITS-1:0]  num_type;
   typedef logic [INT_BITS-1:0]  int_type;

   localparam word_type MAX_POS  = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type MIN_NEG  = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type ONE      = word_type'(1) << FRAC_BITS;
   localparam int_type  FACT_LIM = int_type'(MAX_POS >> FRAC_BITS);

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_FACT = 3'd4,
      OP_POW  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_DIV0    = 2'd1,
      STAT_UNKNOWN = 2'd2,
      STAT_SAT     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_WAIT,
      S_DIV_WAIT,
      S_FACT_WAIT,
      S_POW_NEXT,
      S_POW_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]                  kind;
      logic signed [WORD_BITS-1:0] operand_a;
      logic signed [WORD_BITS-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] result_value;
      logic [1:0]                  status;
   } rsp_type;

   typedef struct packed {
      word_type value;
      logic     sat;
   } pack_type;

endpackage

>>> design/scu_mul.sv
module scu_mul
   import scu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type x,
   input  word_type y,
   output logic     done,
   output prod_type prod
);

   localparam logic [MUL_CNT_BITS-1:0] LAST = MUL_CNT_BITS'(MUL_STEPS - 1);

   logic                    busy_ff, busy_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   word_type                x_ff, x_in;
   word_type                y_ff, y_in;
   logic [PP_BITS-1:0]      pp_ff, pp_in;
   logic                    pp_vld_ff, pp_vld_in;
   logic [MUL_CNT_BITS-1:0] pp_idx_ff, pp_idx_in;
   prod_type                acc_ff, acc_in;
   logic                    done_ff, done_in;

   // One partial product per cycle, accumulated in the following cycle
   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      pp_in     = PP_BITS'(x_ff) * PP_BITS'(y_ff[MUL_DIGIT-1:0]);
      pp_vld_in = busy_ff;
      pp_idx_in = cnt_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;

      if (pp_vld_ff) begin
         acc_in  = acc_ff + (prod_type'(pp_ff) << (MUL_DIGIT * pp_idx_ff));
         done_in = (pp_idx_ff == LAST);
      end

      if (busy_ff) begin
         y_in   = y_ff >> MUL_DIGIT;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end

      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         x_in      = x;
         y_in      = y;
         acc_in    = '0;
         pp_vld_in = 1'b0;
         done_in   = 1'b0;
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         pp_vld_ff <= pp_vld_in;
         done_ff   <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      pp_ff     <= pp_in;
      pp_idx_ff <= pp_idx_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

>>> design/scu_div.sv
module scu_div
   import scu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  num_type  num,
   input  word_type den,
   output logic     done,
   output num_type  quot
);

   localparam logic [DIV_CNT_BITS-1:0] LAST = DIV_CNT_BITS'(NUM_BITS - 1);

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   num_type                 num_ff, num_in;
   word_type                rem_ff, rem_in;
   word_type                den_ff, den_in;
   logic                    done_ff, done_in;
   logic [WORD_BITS:0]      trial;
   logic [WORD_BITS:0]      diff;

   // Restoring division: numerator shifts out the top, quotient bits shift in
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[NUM_BITS-1]};
      diff    = trial - {1'b0, den_ff};

      if (busy_ff) begin
         if (!diff[WORD_BITS]) begin
            rem_in = diff[WORD_BITS-1:0];
            num_in = {num_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[WORD_BITS-1:0];
            num_in = {num_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         done_in = 1'b0;
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

>>> design/scalar_calculator_alu.sv
// Fixed-point calculator, signed Q31.16 words. One item is in work at a time: req_stall is
// high from acceptance until the result is loaded into the output register, which may still
// hold the previous result while the next item is taken. Multiply uses the shared multiply
// unit, which consumes one 16-bit digit of its second operand per cycle. Divide uses the
// divide unit, which produces one quotient bit per cycle over 64 bits. Factorial runs at
// most 12 multiplies before it saturates. Power runs floor(b) multiplies, stopping early on
// overflow or once the chain repeats with period one or two.
module scalar_calculator_alu
   import scu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int QW = PROD_BITS - FRAC_BITS;

   // Magnitude of a two's complement word
   function automatic word_type mag(input word_type v);
      mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   // Product to word: floor toward minus infinity, then saturate
   function automatic pack_type mul_pack(input prod_type p, input logic neg);
      logic [QW-1:0] q;
      logic [QW-1:0] lim;
      logic          rnd;
      pack_type      r;
      q   = p[PROD_BITS-1:FRAC_BITS];
      rnd = neg && (p[FRAC_BITS-1:0] != '0);
      lim = {{(QW-WORD_BITS){1'b0}}, (neg ? MIN_NEG : MAX_POS)};
      r.sat = rnd ? (q >= lim) : (q > lim);
      if (r.sat) begin
         r.value = neg ? MIN_NEG : MAX_POS;
      end else if (neg) begin
         r.value = ~q[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, ~rnd};
      end else begin
         r.value = q[WORD_BITS-1:0];
      end
      mul_pack = r;
   endfunction

   // Quotient magnitude to word, saturating
   function automatic pack_type div_pack(input num_type q, input logic neg);
      num_type  lim;
      pack_type r;
      lim   = {{(NUM_BITS-WORD_BITS){1'b0}}, (neg ? MIN_NEG : MAX_POS)};
      r.sat = q > lim;
      if (r.sat) begin
         r.value = neg ? MIN_NEG : MAX_POS;
      end else if (neg) begin
         r.value = ~q[WORD_BITS-1:0] + 1'b1;
      end else begin
         r.value = q[WORD_BITS-1:0];
      end
      div_pack = r;
   endfunction

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   word_type   a_ff, a_in;
   word_type   b_ff, b_in;
   word_type   res_ff, res_in;
   status_type stat_ff, stat_in;
   logic       sign_ff, sign_in;
   int_type    n_ff, n_in;
   int_type    k_ff, k_in;
   int_type    i_ff, i_in;
   word_type   prev1_ff, prev1_in;
   word_type   prev2_ff, prev2_in;
   logic       have2_ff, have2_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       mul_start, mul_done;
   word_type   mul_x, mul_y;
   prod_type   mul_prod;
   logic       div_start, div_done;
   num_type    div_num, div_quot;
   word_type   div_den;

   word_type   sum, dif;
   pack_type   mpk, dpk;
   int_type    k_next;
   logic       req_take;

   scu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mul_x),
      .y     (mul_y),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   scu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign sum    = a_ff + b_ff;
   assign dif    = a_ff - b_ff;
   assign mpk    = mul_pack(mul_prod, sign_ff);
   assign dpk    = div_pack(div_quot, sign_ff);
   assign k_next = k_ff + 1'b1;

   // Sequencer: next state, operand steering and output register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      sign_in      = sign_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      have2_in     = have2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_x        = mag(a_ff);
      mul_y        = mag(b_ff);
      div_start    = 1'b0;
      div_num      = {mag(a_ff), {FRAC_BITS{1'b0}}};
      div_den      = mag(b_ff);

      // Output register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_data.kind;
               a_in     = word_type'(req_data.operand_a);
               b_in     = word_type'(req_data.operand_b);
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            stat_in  = STAT_OK;
            state_in = S_FINISH;
            case (op_ff)
               OP_ADD: begin
                  res_in = sum;
                  if (a_ff[WORD_BITS-1] == b_ff[WORD_BITS-1] &&
                      sum[WORD_BITS-1] != a_ff[WORD_BITS-1]) begin
                     res_in  = a_ff[WORD_BITS-1] ? MIN_NEG : MAX_POS;
                     stat_in = STAT_SAT;
                  end
               end
               OP_SUB: begin
                  res_in = dif;
                  if (a_ff[WORD_BITS-1] != b_ff[WORD_BITS-1] &&
                      dif[WORD_BITS-1] != a_ff[WORD_BITS-1]) begin
                     res_in  = a_ff[WORD_BITS-1] ? MIN_NEG : MAX_POS;
                     stat_in = STAT_SAT;
                  end
               end
               OP_MUL: begin
                  mul_start = 1'b1;
                  sign_in   = a_ff[WORD_BITS-1] ^ b_ff[WORD_BITS-1];
                  state_in  = S_MUL_WAIT;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     res_in  = '0;
                     stat_in = STAT_DIV0;
                  end else begin
                     div_start = 1'b1;
                     sign_in   = a_ff[WORD_BITS-1] ^ b_ff[WORD_BITS-1];
                     state_in  = S_DIV_WAIT;
                  end
               end
               OP_FACT: begin
                  // negative or floor(a) <= 1 gives one
                  if (a_ff[WORD_BITS-1] ||
                      a_ff[WORD_BITS-1:FRAC_BITS] <= int_type'(1)) begin
                     res_in = ONE;
                  end else begin
                     n_in      = a_ff[WORD_BITS-1:FRAC_BITS];
                     i_in      = int_type'(2);
                     mul_start = 1'b1;
                     mul_x     = word_type'(1);
                     mul_y     = word_type'(2);
                     state_in  = S_FACT_WAIT;
                  end
               end
               OP_POW: begin
                  // negative exponent or zero count gives one
                  if (b_ff[WORD_BITS-1] || b_ff[WORD_BITS-1:FRAC_BITS] == '0) begin
                     res_in = ONE;
                  end else begin
                     n_in     = b_ff[WORD_BITS-1:FRAC_BITS];
                     k_in     = '0;
                     have2_in = 1'b0;
                     prev1_in = ONE;
                     state_in = S_POW_NEXT;
                  end
               end
               default: begin
                  res_in  = a_ff;
                  stat_in = STAT_UNKNOWN;
               end
            endcase
         end

         S_MUL_WAIT: begin
            if (mul_done) begin
               res_in   = mpk.value;
               stat_in  = mpk.sat ? STAT_SAT : STAT_OK;
               state_in = S_FINISH;
            end
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               res_in   = dpk.value;
               stat_in  = dpk.sat ? STAT_SAT : STAT_OK;
               state_in = S_FINISH;
            end
         end

         S_FACT_WAIT: begin
            if (mul_done) begin
               if (mul_prod > prod_type'(FACT_LIM)) begin
                  res_in   = MAX_POS;
                  stat_in  = STAT_SAT;
                  state_in = S_FINISH;
               end else begin
                  if (i_ff == n_ff) begin
                     res_in   = word_type'(mul_prod[INT_BITS-1:0]) << FRAC_BITS;
                     stat_in  = STAT_OK;
                     state_in = S_FINISH;
                  end else begin
                     i_in      = i_ff + 1'b1;
                     mul_start = 1'b1;
                     mul_x     = word_type'(mul_prod[INT_BITS-1:0]);
                     mul_y     = word_type'(i_ff + 1'b1);
                  end
               end
            end
         end

         S_POW_NEXT: begin
            mul_start = 1'b1;
            mul_x     = mag(prev1_ff);
            mul_y     = mag(a_ff);
            sign_in   = prev1_ff[WORD_BITS-1] ^ a_ff[WORD_BITS-1];
            state_in  = S_POW_WAIT;
         end

         S_POW_WAIT: begin
            if (mul_done) begin
               k_in    = k_next;
               stat_in = STAT_OK;
               if (mpk.sat) begin
                  res_in   = mpk.value;
                  stat_in  = STAT_SAT;
                  state_in = S_FINISH;
               end else if (have2_ff && mpk.value == prev2_ff) begin
                  // chain repeats: remaining steps settle by parity
                  res_in   = (n_ff[0] ^ k_next[0]) ? prev1_ff : mpk.value;
                  state_in = S_FINISH;
               end else begin
                  prev2_in = prev1_ff;
                  prev1_in = mpk.value;
                  have2_in = 1'b1;
                  if (k_next == n_ff) begin
                     res_in   = mpk.value;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_POW_NEXT;
                  end
               end
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = res_ff;
               rsp_data_in.status       = stat_ff;
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload and iteration state
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      sign_ff     <= sign_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      prev1_ff    <= prev1_in;
      prev2_ff    <= prev2_in;
      have2_ff    <= have2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/scu_checker.sv
module scu_checker
   import scu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic       pend_ff, pend_in;
   logic       held_ff, held_in;
   logic [2:0] kind_ff, kind_in;
   word_type   a_ff, a_in;
   logic       req_take;
   logic       rsp_new;

   assign req_take = req_valid && !req_stall;
   assign rsp_new  = rsp_valid && !held_ff;

   // Track the item in flight as seen on the ports
   always_comb begin
      held_in = rsp_valid && rsp_stall;
      pend_in = pend_ff;
      kind_in = kind_ff;
      a_in    = a_ff;
      if (rsp_new) begin
         pend_in = 1'b0;
      end
      if (req_take) begin
         pend_in = 1'b1;
         kind_in = req_data.kind;
         a_in    = word_type'(req_data.operand_a);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      a_ff    <= a_in;
   end

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // One item at a time: busy right after an item is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("item accepted while previous one in work");

   // Every result belongs to an accepted item
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_new |-> pend_ff)
      else $error("result without accepted item");

   // Unknown codes echo operand a
   a_unknown_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_new && (kind_ff > OP_POW) |->
         rsp_data.status == STAT_UNKNOWN && rsp_data.result_value == a_ff)
      else $error("unknown code not flagged or operand not returned");

   // Divide-by-zero status only from a divide, with a zero result
   a_div0_source: assert property (@(posedge clock) disable iff (reset)
      rsp_new && rsp_data.status == STAT_DIV0 |->
         kind_ff == OP_DIV && rsp_data.result_value == '0)
      else $error("divide-by-zero status on wrong item");

endmodule

bind scalar_calculator_alu scu_checker u_scu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> sim/scalar_calculator_alu_check.sv
module scalar_calculator_alu_check
   import scu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIGN = WORD_BITS - 1;

   typedef logic [127:0] big_type;

   // Magnitude limit of a negative result: 2^(WORD_BITS-1)
   localparam big_type NEG_LIMIT = big_type'(1) << SIGN;
   localparam pack_type UNIT = '{ONE, 1'b0};

   rsp_type pending_results[$];

   function automatic word_type magnitude(word_type v);
      return v[SIGN] ? word_type'(-v) : v;
   endfunction

   // Sign plus magnitude back into a word, clamped to the word range
   function automatic pack_type fit_word(logic neg, big_type m);
      big_type  lim;
      pack_type p;
      lim = neg ? NEG_LIMIT : big_type'(MAX_POS);
      p.sat = m > lim;
      if (p.sat)
         m = lim;
      p.value = m[WORD_BITS-1:0];
      if (neg)
         p.value = -p.value;
      return p;
   endfunction

   // Fixed-point product, floor rounding on the dropped fraction
   function automatic pack_type scaled_product(word_type a, word_type b);
      big_type p;
      big_type q;
      logic    neg;
      p = big_type'(magnitude(a)) * big_type'(magnitude(b));
      q = p >> FRAC_BITS;
      neg = a[SIGN] ^ b[SIGN];
      if (neg && p[FRAC_BITS-1:0] != '0)
         q = q + 1;
      return fit_word(neg, q);
   endfunction

   // Fixed-point quotient, truncated toward zero; divisor assumed nonzero
   function automatic pack_type scaled_quotient(word_type a, word_type b);
      big_type q;
      q = (big_type'(magnitude(a)) << FRAC_BITS) / big_type'(magnitude(b));
      return fit_word(a[SIGN] ^ b[SIGN], q);
   endfunction

   function automatic pack_type factorial_word(word_type a);
      longint unsigned n;
      longint unsigned prod;
      longint unsigned lim;
      pack_type        p;
      if (a[SIGN])
         return UNIT;
      n = 64'(a >> FRAC_BITS);
      lim = 64'(MAX_POS >> FRAC_BITS);
      prod = 1;
      for (longint unsigned i = 2; i <= n; i++) begin
         if (prod > lim / i) begin
            p.value = MAX_POS;
            p.sat = 1'b1;
            return p;
         end
         prod = prod * i;
      end
      return fit_word(1'b0, big_type'(prod) << FRAC_BITS);
   endfunction

   // a^floor(b) by repeated products; stops on overflow or a repeat of period one or two
   function automatic pack_type power_word(word_type a, word_type b);
      longint unsigned n;
      longint unsigned k;
      word_type        prev2;
      word_type        prev1;
      pack_type        cur;
      logic            have2;
      if (b[SIGN])
         return UNIT;
      n = 64'(b >> FRAC_BITS);
      k = 0;
      prev1 = ONE;
      prev2 = '0;
      have2 = 1'b0;
      while (k < n) begin
         cur = scaled_product(prev1, a);
         k++;
         if (cur.sat)
            return cur;
         if (have2 && cur.value == prev2) begin
            // remaining steps only alternate, parity picks the end value
            if ((n - k) % 2 == 1)
               cur.value = prev1;
            return cur;
         end
         prev2 = prev1;
         prev1 = cur.value;
         have2 = 1'b1;
      end
      return '{prev1, 1'b0};
   endfunction

   function automatic rsp_type calc_result(req_type item);
      rsp_type  r;
      pack_type p;
      word_type a;
      word_type b;
      word_type sum;
      a = item.operand_a;
      b = item.operand_b;
      p.value = '0;
      p.sat = 1'b0;
      r.status = STAT_OK;
      case (item.kind)
         OP_ADD: begin
            sum = a + b;
            if (a[SIGN] == b[SIGN] && sum[SIGN] != a[SIGN]) begin
               p.value = a[SIGN] ? MIN_NEG : MAX_POS;
               p.sat = 1'b1;
            end else begin
               p.value = sum;
            end
         end
         OP_SUB: begin
            sum = a - b;
            if (a[SIGN] != b[SIGN] && sum[SIGN] != a[SIGN]) begin
               p.value = a[SIGN] ? MIN_NEG : MAX_POS;
               p.sat = 1'b1;
            end else begin
               p.value = sum;
            end
         end
         OP_MUL: p = scaled_product(a, b);
         OP_DIV: begin
            if (b == '0)
               r.status = STAT_DIV0;
            else
               p = scaled_quotient(a, b);
         end
         OP_FACT: p = factorial_word(a);
         OP_POW: p = power_word(a, b);
         default: begin
            p.value = a;
            r.status = STAT_UNKNOWN;
         end
      endcase
      if (p.sat)
         r.status = STAT_SAT;
      r.result_value = p.value;
      return r;
   endfunction

   initial begin
      failures = 0;
      waiting = 0;
   end

   // Queue a prediction per accepted item, match results in order
   always @(posedge clock) begin : watch
      rsp_type want;
      int      bad;
      bad = 0;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_results.push_back(calc_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result with none outstanding: result_value %h, status %0d",
                      rsp_data.result_value, rsp_data.status);
               bad++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %h, got %h",
                         want.result_value, rsp_data.result_value);
                  bad++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  bad++;
               end
            end
         end
         failures <= failures + bad;
         waiting <= pending_results.size();
      end
   end

endmodule

>>> sim/scalar_calculator_alu_test.sv
module scalar_calculator_alu_test;
   import scu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIGN = WORD_BITS - 1;
   localparam int RANDOM_ITEMS = 600;

   // Codes past the last operation
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam word_type NEG_ONE  = -ONE;
   localparam word_type ALL_ONES = '1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      waiting;

   logic calm = 1'b0;
   int   send_odds = 4;
   int   stall_odds = 4;
   int   stall_run = 0;

   scalar_calculator_alu DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   scalar_calculator_alu_check result_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .waiting   (waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver backpressure in bursts
   always @(negedge clock) begin
      if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_run <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type item_of(logic [2:0] kind, word_type a, word_type b);
      req_type item;
      item.kind = kind;
      item.operand_a = a;
      item.operand_b = b;
      return item;
   endfunction

   function automatic word_type whole(int k);
      return word_type'(k) << FRAC_BITS;
   endfunction

   // Mostly full-width noise, with extremes, small whole numbers and fractions
   function automatic word_type random_operand();
      case ($urandom_range(0, 10))
         0: return MAX_POS;
         1: return MIN_NEG;
         2: return whole($urandom_range(0, 8)) - whole(4);
         3: return word_type'($urandom_range(0, 65535)) - word_type'(32768);
         4: return '0;
         default: return word_type'({$urandom(), $urandom()});
      endcase
   endfunction

   // Power operands chosen so the multiply chain ends in few steps
   task automatic power_operands(output word_type a, output word_type b);
      word_type mag;
      case ($urandom_range(0, 3))
         0: begin
            a = random_operand();
            b = whole($urandom_range(0, 63)) | word_type'($urandom_range(0, 65535));
         end
         1: begin
            // base within +-2.0
            a = word_type'($urandom_range(0, 1 << (FRAC_BITS + 2))) - whole(2);
            b = whole($urandom_range(0, 63)) | word_type'($urandom_range(0, 65535));
         end
         2: begin
            // huge exponent: base must overflow, decay or repeat quickly
            a = random_operand();
            mag = a[SIGN] ? word_type'(-a) : a;
            if (mag > (ONE >> 1) && mag < whole(2))
               a = a[SIGN] ? NEG_ONE : ONE;
            b = random_operand() & MAX_POS;
         end
         default: begin
            a = random_operand();
            b = random_operand() | MIN_NEG;
         end
      endcase
   endtask

   task automatic push_item(req_type item);
      if (!calm && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Hold off the sender until every outstanding result is back
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      do
         @(posedge clock);
      while (waiting != 0);
   endtask

   initial begin : stimulus
      logic [2:0] kind;
      word_type   a;
      word_type   b;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: saturation edges, rounding, divide by zero, chain shortcuts
      push_item(item_of(OP_ADD, MAX_POS, whole(0) + 1));
      push_item(item_of(OP_ADD, MIN_NEG, ALL_ONES));
      push_item(item_of(OP_SUB, MIN_NEG, whole(0) + 1));
      push_item(item_of(OP_SUB, MAX_POS, ALL_ONES));
      push_item(item_of(OP_ADD, '0, '0));
      push_item(item_of(OP_MUL, ALL_ONES, ONE >> 1));
      push_item(item_of(OP_MUL, MAX_POS, MAX_POS));
      push_item(item_of(OP_MUL, MIN_NEG, NEG_ONE));
      push_item(item_of(OP_MUL, MIN_NEG, ONE));
      push_item(item_of(OP_DIV, whole(5), '0));
      push_item(item_of(OP_DIV, ALL_ONES, whole(3)));
      push_item(item_of(OP_DIV, MIN_NEG, ALL_ONES));
      push_item(item_of(OP_DIV, MAX_POS, MAX_POS));
      push_item(item_of(OP_FACT, NEG_ONE, MAX_POS));
      push_item(item_of(OP_FACT, ONE + (ONE >> 1), '0));
      push_item(item_of(OP_FACT, whole(12), '0));
      push_item(item_of(OP_FACT, whole(13), '0));
      push_item(item_of(OP_FACT, MAX_POS, MIN_NEG));
      push_item(item_of(OP_POW, whole(2), NEG_ONE));
      push_item(item_of(OP_POW, whole(2), ONE >> 1));
      push_item(item_of(OP_POW, whole(2), whole(10)));
      push_item(item_of(OP_POW, NEG_ONE, MAX_POS));
      push_item(item_of(OP_POW, NEG_ONE, MAX_POS - ONE));
      push_item(item_of(OP_POW, ONE, MAX_POS));
      push_item(item_of(OP_POW, -whole(3), whole(31)));
      push_item(item_of(OP_SPARE_LO, MIN_NEG, MAX_POS));
      push_item(item_of(OP_SPARE_HI, MAX_POS, MIN_NEG));
      drain();

      // Random items: moderate idling, then heavy stall, then none at all
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 250) begin
            drain();
            send_odds = 8;
            stall_odds = 2;
         end
         if (n == 450)
            calm = 1'b1;
         kind = 3'($urandom_range(0, 7));
         if (kind == OP_POW) begin
            power_operands(a, b);
         end else begin
            a = random_operand();
            b = random_operand();
         end
         push_item(item_of(kind, a, b));
      end
      drain();
      repeat (100) @(posedge clock);

      if (failures == 0 && waiting == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #(30_000_000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
design/scu_pkg.sv
design/scu_mul.sv
design/scu_div.sv
design/scalar_calculator_alu.sv
design/scu_checker.sv
sim/scalar_calculator_alu_check.sv
sim/scalar_calculator_alu_test.sv
